### hdl/fatigue_life_from_stress_unit_macros.svh
// Assertion macros shared by the fatigue life block.
`ifndef FATIGUE_LIFE_FROM_STRESS_UNIT_MACROS_SVH
`define FATIGUE_LIFE_FROM_STRESS_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define FLFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fatigue life block: check failed");
// Next-cycle implication, disabled while reset is low.
`define FLFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fatigue life block: check failed");
`else
`define FLFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FLFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/flfs_pkg.sv
package flfs_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUMSQ,
        S_SQRT,
        S_AMP,
        S_LOG,
        S_PROD,
        S_EXP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_STRENGTH = 2'd1;
    localparam logic [1:0] CFG_EXPONENT = 2'd2;

    localparam int          RAD_W    = 62;
    localparam int          ROOT_W   = 31;
    localparam int          ROOT_N   = 30;
    localparam logic [47:0] LIFE_MAX = 48'hFFFF_FFFF_FFFF;
    // 48.0 in the Q.46 exponent format.
    localparam logic [51:0] EXP_SAT  = 52'hC_0000_0000_0000;

    typedef logic [31:0] t_root_tab [ROOT_N];

    // Successive square roots of 2.0 in Q1.31, each the floor root of the one before.
    function automatic t_root_tab f_root_tab();
        logic [63:0] c;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] cand;
        t_root_tab   t;
        c = 64'h1_0000_0000;
        for (int i = 0; i < ROOT_N; i++) begin
            n = c << 31;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                if (cand * cand <= n) r = cand;
            end
            c    = r;
            t[i] = r[31:0];
        end
        return t;
    endfunction

    localparam t_root_tab ROOT_TAB = f_root_tab();

endpackage

### hdl/flfs_mul.sv
module flfs_mul (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output logic [65:0] o_p
);
    logic [65:0] r_p;

    // The product register is the only stage; operands come from registers upstream.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

### hdl/flfs_sqrt.sv
module flfs_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [flfs_pkg::RAD_W-1:0]  i_radicand,
    output logic [flfs_pkg::ROOT_W-1:0] o_root,
    output flfs_pkg::t_sqrt_stat      o_stat
);
    import flfs_pkg::*;

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+3:0] w_rem_sh;
    logic [ROOT_W+3:0] w_trial;
    logic              w_fit;

    // Restoring square root: two radicand bits in and one root bit out per cycle.
    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_fit ? (ROOT_W+2)'(w_rem_sh - w_trial) : (ROOT_W+2)'(w_rem_sh);
            r_root <= {r_root[ROOT_W-2:0], w_fit};
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

### hdl/fatigue_life_from_stress_unit.sv
// Channel    Direction  Handshake            Payload
// node in    input      i_valid / o_ready    six stress components, last-node flag
// result     output     o_valid / i_ready    amplitude, life, worst node, set done
// config     input      i_cfg_we             i_cfg_index, i_cfg_data
//
// An item passes from acceptance to a waiting result through the sum of squares, the
// square root unit, the forming of the amplitude, the two base-two logarithms, the
// exponent product, the power of two and the load of the result register. The block
// is ready again only once it is back in idle, so it takes no new item while one is
// in work. The sum of squares, the logarithms, the product and the power of two run on
// the one shared 33 by 33 bit multiplier; the square root has its own unit.
// A saturated sum of squares skips the square root, and a zero amplitude, a unit life
// or a saturated exponent skips the later steps.
// Reset is synchronous and active low; it restores the register defaults and clears
// the node count and the worst node. The result waits in an output register, so a new
// item is taken while it stalls, but the next result is held until it is taken.
module fatigue_life_from_stress_unit #(
    parameter int MAX_NODES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_stress_xx,
    input  logic [31:0] i_stress_yy,
    input  logic [31:0] i_stress_zz,
    input  logic [31:0] i_shear_xy,
    input  logic [31:0] i_shear_xz,
    input  logic [31:0] i_shear_yz,
    input  logic        i_last_node,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_stress_amplitude,
    output logic [47:0] o_life_cycles,
    output logic        o_life_infinite,
    output logic [15:0] o_worst_node_index,
    output logic [31:0] o_peak_amplitude,
    output logic [47:0] o_peak_life,
    output logic        o_worst_infinite,
    output logic        o_set_done,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import flfs_pkg::*;

    `include "fatigue_life_from_stress_unit_macros.svh"

    t_state r_state, n_state;
    logic [4:0] r_cnt;
    logic       r_pass;

    // configuration
    logic        r_mode;
    logic [30:0] r_strength;
    logic [31:0] r_lexp;

    // the accepted item
    logic [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    logic        r_last;
    logic        r_hneg;

    // working registers
    logic [68:0] r_acc;
    logic [30:0] r_mag;
    logic        r_inf;
    logic [31:0] r_m;
    logic [4:0]  r_msb;
    logic [29:0] r_frac;
    logic [34:0] r_la, r_lb, r_ud;
    logic        r_neg;
    logic [63:0] r_plo;
    logic [66:0] r_big;
    logic [6:0]  r_k;
    logic [29:0] r_fbits;
    logic [31:0] r_mx;
    logic [47:0] r_life;

    // per-set running state
    logic [15:0] r_pos, r_wpos;
    logic        r_wseen, r_winf;
    logic [30:0] r_wabs;
    logic [31:0] r_wamp;
    logic [47:0] r_wlife;

    // result register
    logic        r_ovalid;
    logic [31:0] r_out_amp, r_out_wamp;
    logic [47:0] r_out_life, r_out_wlife;
    logic        r_out_inf, r_out_winf, r_out_done;
    logic [15:0] r_out_wpos;

    logic [32:0] w_op_a, w_op_b;
    logic [65:0] w_prod;
    logic [30:0] w_root;
    t_sqrt_stat  w_sqrt_stat;
    logic        w_sqrt_start;

    logic [33:0] w_hsum;
    logic [32:0] w_dxy, w_dyz, w_dzx;
    logic [32:0] w_term;
    logic [68:0] w_add;
    logic        w_acc_sat;
    logic [31:0] w_norm, w_x_init, w_a_eff, w_mcur;
    logic [29:0] w_frac_fin;
    logic        w_pass_end, w_log_end;
    logic [35:0] w_d;
    logic [31:0] w_ub;
    logic        w_unit_life;
    logic        w_big, w_ge48;
    logic [52:0] w_e;
    logic [7:0]  w_rsh;
    logic [47:0] w_life_exp;
    logic        w_load, w_upd;
    logic [31:0] w_amp;
    logic [16:0] w_next_pos;

    function automatic logic [4:0] f_msb(input logic [31:0] x);
        logic [4:0] m;
        m = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) m = 5'(i);
        end
        return m;
    endfunction

    function automatic logic [32:0] f_mag33(input logic [32:0] d);
        return d[32] ? 33'(-d) : d;
    endfunction

    function automatic logic [31:0] f_abs32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    flfs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_p   (w_prod)
    );

    flfs_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (r_acc[RAD_W:1]),
        .o_root     (w_root),
        .o_stat     (w_sqrt_stat)
    );

    // Hydrostatic sign is taken from the incoming item, as an exact 34-bit sum.
    assign w_hsum = {{2{i_stress_xx[31]}}, i_stress_xx} + {{2{i_stress_yy[31]}}, i_stress_yy}
                  + {{2{i_stress_zz[31]}}, i_stress_zz};

    assign w_dxy = {r_xx[31], r_xx} - {r_yy[31], r_yy};
    assign w_dyz = {r_yy[31], r_yy} - {r_zz[31], r_zz};
    assign w_dzx = {r_zz[31], r_zz} - {r_xx[31], r_xx};

    always_comb begin
        case (r_cnt)
            5'd0:    w_term = f_mag33(w_dxy);
            5'd1:    w_term = f_mag33(w_dyz);
            5'd2:    w_term = f_mag33(w_dzx);
            5'd3:    w_term = f_mag33({r_xy[31], r_xy});
            5'd4:    w_term = f_mag33({r_xz[31], r_xz});
            5'd5:    w_term = f_mag33({r_yz[31], r_yz});
            default: w_term = '0;
        endcase
    end

    // The shear squares carry a weight of six, added as four plus two times.
    assign w_add = (r_cnt >= 5'd4) ? (69'({w_prod, 2'b00}) + 69'({w_prod, 1'b0}))
                                   : 69'(w_prod);
    assign w_acc_sat = (r_acc[68:63] != '0);

    // Repeated squaring of the mantissa: a product at or above 2.0 gives a one bit.
    assign w_norm     = w_prod[63] ? w_prod[63:32] : w_prod[62:31];
    assign w_frac_fin = {r_frac[28:0], w_prod[63]};
    assign w_log_end  = (r_state == S_LOG) && (r_cnt == 5'd30);
    assign w_pass_end = w_log_end && !r_pass;
    assign w_a_eff    = (r_strength == '0) ? 32'd1 : {1'b0, r_strength};
    assign w_x_init   = w_pass_end ? w_a_eff : {1'b0, r_mag};

    assign w_d         = {1'b0, r_la} - {1'b0, r_lb};
    assign w_ub        = r_lexp[31] ? 32'(-r_lexp) : r_lexp;
    assign w_unit_life = (r_la == r_lb) || (r_lexp == '0);
    assign w_big       = (r_big[66:52] != '0);
    assign w_ge48      = !r_neg && (r_big[51:0] >= EXP_SAT);
    assign w_e         = r_neg ? 53'(-r_big[52:0]) : r_big[52:0];

    // Power of two: fraction bits pick root factors, one multiply per bit.
    assign w_mcur = (r_cnt == '0) ? 32'h8000_0000 : (r_fbits[29] ? w_prod[62:31] : r_mx);
    assign w_rsh  = 8'sd31 - {r_k[6], r_k};

    always_comb begin
        if ($signed(r_k) >= 7'sd31) begin
            w_life_exp = 48'({16'b0, w_mcur} << 5'(r_k - 7'd31));
        end else if (w_rsh >= 8'd32) begin
            w_life_exp = '0;
        end else begin
            w_life_exp = {16'b0, w_mcur >> w_rsh[4:0]};
        end
    end

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            S_SUMSQ: begin
                w_op_a = w_term;
                w_op_b = w_term;
            end
            S_LOG: begin
                w_op_a = {1'b0, (r_cnt == '0) ? r_m : w_norm};
                w_op_b = w_op_a;
            end
            S_PROD: begin
                w_op_b = {1'b0, w_ub};
                if (r_cnt == 5'd1) w_op_a = {1'b0, r_ud[31:0]};
                else               w_op_a = {30'b0, r_ud[34:32]};
            end
            S_EXP: begin
                w_op_a = {1'b0, w_mcur};
                if (r_cnt < 5'(ROOT_N)) w_op_b = {1'b0, ROOT_TAB[r_cnt]};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // Sequencer: next state and handshake.
    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        w_sqrt_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = S_SUMSQ;
            end
            S_SUMSQ: begin
                if (r_cnt == 5'd7) begin
                    if (w_acc_sat) begin
                        n_state = S_AMP;
                    end else begin
                        n_state      = S_SQRT;
                        w_sqrt_start = 1'b1;
                    end
                end
            end
            S_SQRT: begin
                if (w_sqrt_stat.done) n_state = S_AMP;
            end
            S_AMP: begin
                n_state = (r_mag == '0) ? S_FINISH : S_LOG;
            end
            S_LOG: begin
                if (w_log_end && r_pass) n_state = S_PROD;
            end
            S_PROD: begin
                if (r_cnt == 5'd0 && w_unit_life) n_state = S_FINISH;
                else if (r_cnt == 5'd4) n_state = (w_big || w_ge48) ? S_FINISH : S_EXP;
            end
            S_EXP: begin
                if (r_cnt == 5'd30) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_ovalid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_load     = (r_state == S_FINISH) && (!r_ovalid || i_ready);
    assign w_upd      = !r_wseen || (r_mag > r_wabs);
    assign w_amp      = (r_mode && r_hneg) ? 32'(-{1'b0, r_mag}) : {1'b0, r_mag};
    assign w_next_pos = {1'b0, r_pos} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control, configuration and per-set state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pass     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_mode     <= 1'b0;
            r_strength <= 31'd256000;
            r_lexp     <= 32'hFFF6_0000;
            r_pos      <= '0;
            r_wseen    <= 1'b0;
            r_wpos     <= '0;
            r_wabs     <= '0;
            r_wamp     <= '0;
            r_wlife    <= '0;
            r_winf     <= 1'b0;
        end else begin
            r_cnt <= (n_state != r_state || w_pass_end) ? 5'd0 : r_cnt + 5'd1;
            if (r_state == S_AMP) r_pass <= 1'b0;
            else if (w_pass_end)  r_pass <= 1'b1;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:     r_mode     <= i_cfg_data[0];
                    CFG_STRENGTH: r_strength <= i_cfg_data[30:0];
                    CFG_EXPONENT: r_lexp     <= i_cfg_data;
                    default:      ;
                endcase
            end

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            if (w_load) begin
                if (r_last) begin
                    r_pos   <= '0;
                    r_wseen <= 1'b0;
                    r_wpos  <= '0;
                    r_wabs  <= '0;
                    r_wamp  <= '0;
                    r_wlife <= '0;
                    r_winf  <= 1'b0;
                end else begin
                    if (32'(w_next_pos) >= MAX_NODES) r_pos <= '0;
                    else                              r_pos <= w_next_pos[15:0];
                    if (w_upd) begin
                        r_wseen <= 1'b1;
                        r_wpos  <= r_pos;
                        r_wabs  <= r_mag;
                        r_wamp  <= w_amp;
                        r_wlife <= r_life;
                        r_winf  <= r_inf;
                    end
                end
            end
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_xx   <= i_stress_xx;
                r_yy   <= i_stress_yy;
                r_zz   <= i_stress_zz;
                r_xy   <= i_shear_xy;
                r_xz   <= i_shear_xz;
                r_yz   <= i_shear_yz;
                r_last <= i_last_node;
                r_hneg <= w_hsum[33];
                r_acc  <= '0;
            end
            S_SUMSQ: begin
                if (r_cnt >= 5'd1 && r_cnt <= 5'd6) r_acc <= r_acc + w_add;
                if (r_cnt == 5'd7 && w_acc_sat) r_mag <= 31'h7FFF_FFFF;
            end
            S_SQRT: begin
                if (w_sqrt_stat.done) r_mag <= w_root;
            end
            S_AMP: begin
                r_inf  <= (r_mag == '0);
                r_life <= '0;
                r_msb  <= f_msb(w_x_init);
                r_m    <= w_x_init << (5'd31 - f_msb(w_x_init));
            end
            S_LOG: begin
                if (r_cnt != '0) r_frac <= w_frac_fin;
                if (w_pass_end) begin
                    r_la  <= {r_msb, w_frac_fin};
                    r_msb <= f_msb(w_x_init);
                    r_m   <= w_x_init << (5'd31 - f_msb(w_x_init));
                end else if (w_log_end) begin
                    r_lb <= {r_msb, w_frac_fin};
                end
            end
            S_PROD: begin
                case (r_cnt)
                    5'd0: begin
                        r_ud   <= w_d[35] ? 35'(-w_d) : w_d[34:0];
                        r_neg  <= w_d[35] ^ r_lexp[31];
                        r_life <= 48'd1;
                    end
                    5'd2: r_plo <= w_prod[63:0];
                    5'd3: r_big <= 67'(r_plo) + {w_prod[34:0], 32'b0};
                    5'd4: begin
                        r_k     <= w_e[52:46];
                        r_fbits <= w_e[45:16];
                        if (w_big) r_life <= r_neg ? 48'd0 : LIFE_MAX;
                        else if (w_ge48) r_life <= LIFE_MAX;
                    end
                    default: ;
                endcase
            end
            S_EXP: begin
                r_mx <= w_mcur;
                if (r_cnt != '0) r_fbits <= {r_fbits[28:0], 1'b0};
                if (r_cnt == 5'd30) r_life <= w_life_exp;
            end
            default: ;
        endcase

        if (w_load) begin
            r_out_amp   <= w_amp;
            r_out_life  <= r_life;
            r_out_inf   <= r_inf;
            r_out_done  <= r_last;
            r_out_wpos  <= w_upd ? r_pos  : r_wpos;
            r_out_wamp  <= w_upd ? w_amp  : r_wamp;
            r_out_wlife <= w_upd ? r_life : r_wlife;
            r_out_winf  <= w_upd ? r_inf  : r_winf;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_stress_amplitude = r_out_amp;
    assign o_life_cycles      = r_out_life;
    assign o_life_infinite    = r_out_inf;
    assign o_worst_node_index = r_out_wpos;
    assign o_peak_amplitude   = r_out_wamp;
    assign o_peak_life        = r_out_wlife;
    assign o_worst_infinite   = r_out_winf;
    assign o_set_done         = r_out_done;

    // An unbounded life always reports zero cycles.
    `FLFS_ASSERT_IMPL(a_inf_zero_life, i_clk, i_rst_n, o_valid && o_life_infinite, o_life_cycles == 48'd0)
    // The worst node of a result is never milder than the node itself.
    `FLFS_ASSERT_IMPL(a_worst_dominates, i_clk, i_rst_n, o_valid, f_abs32(o_peak_amplitude) >= f_abs32(o_stress_amplitude))
    // The root unit is only started when it is free.
    `FLFS_ASSERT_IMPL(a_sqrt_free, i_clk, i_rst_n, w_sqrt_start, !w_sqrt_stat.busy)
    // An accepted item starts the sum of squares at once.
    `FLFS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready, r_state == S_SUMSQ && r_cnt == 5'd0)
endmodule
